// File: rtl/slcc_pkg.sv
// Shared types, codes and lookup helpers for the snooping coherence line controller.
package slcc_pkg;

  // Protocol modes
  localparam logic [2:0] PROTO_MI    = 3'd0;
  localparam logic [2:0] PROTO_MSI   = 3'd1;
  localparam logic [2:0] PROTO_MESI  = 3'd2;
  localparam logic [2:0] PROTO_MOESI = 3'd3;
  localparam logic [2:0] PROTO_MESIF = 3'd4;

  // Snooped bus kinds
  localparam logic [2:0] BK_RD     = 3'd0;
  localparam logic [2:0] BK_WR     = 3'd1;
  localparam logic [2:0] BK_DATA   = 3'd2;
  localparam logic [2:0] BK_SHARED = 3'd3;

  // Outgoing message codes
  localparam logic [2:0] MS_NONE   = 3'd0;
  localparam logic [2:0] MS_BUSRD  = 3'd1;
  localparam logic [2:0] MS_BUSWR  = 3'd2;
  localparam logic [2:0] MS_DATA   = 3'd3;
  localparam logic [2:0] MS_SHARED = 3'd4;
  localparam logic [2:0] MS_ACK    = 3'd5;
  localparam logic [2:0] MS_SDATA  = 3'd6;

  // Line states
  localparam logic [3:0] ST_I   = 4'd0;
  localparam logic [3:0] ST_M   = 4'd1;
  localparam logic [3:0] ST_S   = 4'd2;
  localparam logic [3:0] ST_E   = 4'd3;
  localparam logic [3:0] ST_O   = 4'd4;
  localparam logic [3:0] ST_F   = 4'd5;
  localparam logic [3:0] ST_IM  = 4'd6;
  localparam logic [3:0] ST_IS  = 4'd7;
  localparam logic [3:0] ST_SM  = 4'd8;
  localparam logic [3:0] ST_ISE = 4'd9;

  // Cache actions
  localparam logic [1:0] CA_NONE = 2'd0;
  localparam logic [1:0] CA_INV  = 2'd1;
  localparam logic [1:0] CA_RECV = 2'd2;

  // Register indexes (paddr bit 2)
  localparam logic REG_PROTOCOL_MODE = 1'b0;
  localparam logic REG_OWN_PROC_ID   = 1'b1;

  localparam int ADDR_W = 3;

  typedef struct packed {
    logic        action;
    logic        is_read_access;
    logic [2:0]  bus_kind;
    logic [3:0]  line_state;
    logic [63:0] line_addr;
    logic [3:0]  source_proc;
    logic [15:0] message_number;
  } slcc_in_t;

  typedef struct packed {
    logic [3:0]  next_line_state;
    logic        perm_granted;
    logic [1:0]  cache_act;
    logic        bad_state;
    logic [2:0]  first_msg;
    logic [2:0]  second_msg;
    logic [63:0] msg_addr;
    logic [3:0]  msg_dest;
    logic [15:0] msg_number;
  } slcc_out_t;

  // Configuration handed from the register block to the decode
  typedef struct packed {
    logic [2:0] protocol_mode;
    logic [3:0] own_proc_id;
  } slcc_cfg_t;

  // States that each protocol uses, one bit per state code
  function automatic logic [15:0] supported_mask(input logic [2:0] mode);
    logic [15:0] m;
    case (mode)
      PROTO_MSI:   m = 16'h01C7;
      PROTO_MESI:  m = 16'h034F;
      PROTO_MOESI: m = 16'h035F;
      PROTO_MESIF: m = 16'h036F;
      default:     m = 16'h0043;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/slcc_cfg_regs.sv
// APB register block holding the protocol mode and the processor number.
module slcc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slcc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output slcc_pkg::slcc_cfg_t         cfg
);
  import slcc_pkg::*;

  logic [2:0] mode_r;
  logic [3:0] id_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= PROTO_MI;
      id_r   <= 4'd0;
    end else if (wr_en) begin
      if (paddr[2] == REG_PROTOCOL_MODE) begin
        mode_r <= pwdata[2:0];
      end else begin
        id_r <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_OWN_PROC_ID) begin
      prdata = {28'd0, id_r};
    end else begin
      prdata = {29'd0, mode_r};
    end
  end

  assign cfg.protocol_mode = mode_r;
  assign cfg.own_proc_id   = id_r;

endmodule

// File: rtl/slcc_decode.sv
// Next-state, permission and message decode for one access or snoop word.
module slcc_decode (
  input  slcc_pkg::slcc_in_t  in_word,
  input  logic [2:0]          protocol_mode,
  output slcc_pkg::slcc_out_t out_word
);
  import slcc_pkg::*;

  logic [2:0]  p;
  logic [15:0] mask;
  logic [3:0]  st;
  logic [2:0]  k;
  logic        rd;
  logic        k_req;
  logic [3:0]  nst;
  logic        perm;
  logic [1:0]  act;
  logic        bad;
  logic [2:0]  msg0;
  logic [2:0]  msg1;
  logic        any_msg;

  // Reserved modes fall back to MI
  assign p     = (protocol_mode > PROTO_MESIF) ? PROTO_MI : protocol_mode;
  assign mask  = supported_mask(p);
  assign st    = in_word.line_state;
  assign k     = in_word.bus_kind;
  assign rd    = in_word.is_read_access;
  assign k_req = (k == BK_RD) || (k == BK_WR);

  always_comb begin
    nst  = st;
    perm = 1'b0;
    act  = CA_NONE;
    bad  = 1'b0;
    msg0 = MS_NONE;
    msg1 = MS_NONE;
    if (st > ST_ISE || !mask[st]) begin
      nst = ST_I;
      bad = 1'b1;
    end else if (!in_word.action) begin
      case (st)
        ST_I: begin
          if (rd && p != PROTO_MI) begin
            msg0 = MS_BUSRD;
            nst  = (p == PROTO_MSI) ? ST_IS : ST_ISE;
          end else begin
            msg0 = MS_BUSWR;
            nst  = ST_IM;
          end
        end
        ST_M: perm = 1'b1;
        ST_S, ST_O, ST_F: begin
          if (rd) begin
            perm = 1'b1;
          end else begin
            msg0 = MS_BUSWR;
            nst  = ST_SM;
          end
        end
        ST_E: begin
          perm = 1'b1;
          if (!rd) nst = ST_M;
        end
        ST_SM: perm = rd;
        ST_IM: bad = 1'b1;
        default: begin
          if (!rd) begin
            msg0 = MS_BUSWR;
            nst  = ST_IM;
          end
        end
      endcase
    end else begin
      case (st)
        ST_I: begin
          if (k_req) msg0 = MS_ACK;
        end
        ST_M: begin
          if (p == PROTO_MI) begin
            msg0 = MS_DATA;
            act  = CA_INV;
            nst  = ST_I;
          end else if (p == PROTO_MSI) begin
            msg0 = MS_DATA;
            if (k == BK_RD) begin
              nst = ST_S;
            end else if (k == BK_WR) begin
              act = CA_INV;
              nst = ST_I;
            end
          end else if (k == BK_RD) begin
            msg0 = MS_SDATA;
            nst  = (p == PROTO_MOESI) ? ST_O : ST_S;
          end else if (k == BK_WR) begin
            msg0 = MS_DATA;
            act  = CA_INV;
            nst  = ST_I;
          end
        end
        ST_O, ST_F: begin
          if (k == BK_RD) begin
            msg0 = MS_SDATA;
            if (st == ST_F) nst = ST_S;
          end else if (k == BK_WR) begin
            msg0 = MS_DATA;
            act  = CA_INV;
            nst  = ST_I;
          end
        end
        ST_E: begin
          if (k == BK_RD) begin
            msg0 = MS_SHARED;
            nst  = ST_S;
          end else if (k == BK_SHARED) begin
            nst = ST_S;
          end else if (k == BK_WR) begin
            msg0 = MS_ACK;
            act  = CA_INV;
            nst  = ST_I;
          end
        end
        ST_S: begin
          if (k == BK_WR) begin
            msg0 = MS_ACK;
            act  = CA_INV;
            nst  = ST_I;
          end else if (k == BK_RD) begin
            // MESI answers Shared then Ack; MOESI Shared only; others Ack only
            if (p == PROTO_MESI) begin
              msg0 = MS_SHARED;
              msg1 = MS_ACK;
            end else if (p == PROTO_MOESI) begin
              msg0 = MS_SHARED;
            end else begin
              msg0 = MS_ACK;
            end
          end
        end
        ST_SM, ST_IM: begin
          if (k_req) msg0 = MS_ACK;
          if (k == BK_DATA || (p == PROTO_MI && k == BK_SHARED)) begin
            act = CA_RECV;
            nst = ST_M;
          end
        end
        ST_IS: begin
          if (k_req) msg0 = MS_ACK;
          if (k == BK_DATA) begin
            act = CA_RECV;
            nst = ST_S;
          end
        end
        default: begin
          if (k_req) msg0 = MS_ACK;
          if (k == BK_DATA) begin
            act = CA_RECV;
            nst = ST_E;
          end else if (k == BK_SHARED) begin
            act = CA_RECV;
            nst = (p == PROTO_MESIF) ? ST_F : ST_S;
          end
        end
      endcase
    end
  end

  assign any_msg = (msg0 != MS_NONE);

  always_comb begin
    out_word.next_line_state = nst;
    out_word.perm_granted    = perm;
    out_word.cache_act       = act;
    out_word.bad_state       = bad;
    out_word.first_msg       = msg0;
    out_word.second_msg      = msg1;
    out_word.msg_addr        = any_msg ? in_word.line_addr : 64'd0;
    // Replies go back to the snoop's sender; requests are broadcast
    out_word.msg_dest        = (any_msg && in_word.action) ? in_word.source_proc : 4'd0;
    out_word.msg_number      = (any_msg && in_word.action) ? in_word.message_number : 16'd0;
  end

endmodule

// File: rtl/snooping_coherence_line_controller.sv
// Top level of the snooping coherence line controller.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------
//  input    | start, busy (always low)     | in_data  (slcc_in_t)
//  result   | out_strobe, one cycle        | out_data (slcc_out_t)
//  config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One word is taken every cycle; each result passes the input register, then the decode
// into the result register, before it appears on out_data.
// The rate is set by the single decode stage between those two registers.
// Synchronous reset clears both valid flags; the payload registers are not reset.
// The receiver takes every result in its strobe cycle; nothing stalls.
module snooping_coherence_line_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  slcc_pkg::slcc_in_t          in_data,
  output logic                        out_strobe,
  output slcc_pkg::slcc_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slcc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import slcc_pkg::*;

  slcc_cfg_t cfg;
  logic      in_valid_r;
  slcc_in_t  in_data_r;
  logic      out_valid_r;
  slcc_out_t out_data_r;
  slcc_out_t dec_out;

  assign busy = 1'b0;

  slcc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    if (start && !busy) in_data_r <= in_data;
    if (in_valid_r) out_data_r <= dec_out;
  end

  slcc_decode u_dec (
    .in_word       (in_data_r),
    .protocol_mode (cfg.protocol_mode),
    .out_word      (dec_out)
  );

  assign out_strobe = out_valid_r;
  assign out_data   = out_data_r;

endmodule

// File: rtl/slcc_checker.sv
// Port-level checker for the snooping coherence line controller, with its bind.
module slcc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input slcc_pkg::slcc_out_t out_data
);
  import slcc_pkg::*;

  // Every accepted word yields a result once through the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("accepted word produced no result");

  // No result without an accepted word
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without accepted word");

  // Unsupported state drops to I with nothing else
  a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.bad_state && out_data.next_line_state != ST_IM) |->
      (out_data.next_line_state == ST_I && out_data.first_msg == MS_NONE &&
       !out_data.perm_granted && out_data.cache_act == CA_NONE))
    else $error("unsupported state result not cleared");

  // Message fields stay zero when nothing is sent
  a_no_msg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.first_msg == MS_NONE) |->
      (out_data.msg_addr == 64'd0 && out_data.msg_dest == 4'd0 &&
       out_data.msg_number == 16'd0 && out_data.second_msg == MS_NONE))
    else $error("message fields set without a message");

  // Grant (accesses) and cache action (snoops) never come together
  a_perm_vs_act: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.perm_granted) |-> (out_data.cache_act == CA_NONE))
    else $error("grant and cache action together");

endmodule

bind snooping_coherence_line_controller slcc_checker u_slcc_checker (.*);

// File: bench/snooping_coherence_line_controller_tb.sv
// Self-checking testbench for the snooping coherence line controller: directed and random words.
module snooping_coherence_line_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slcc_pkg::*;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_SNOOP  = 1'b1;

  // Modes beyond MESIF fall back to MI
  localparam logic [2:0] PROTO_RSVD_A = 3'd5;
  localparam logic [2:0] PROTO_RSVD_B = 3'd6;
  localparam logic [2:0] PROTO_RSVD_C = 3'd7;

  localparam logic [2:0] BK_ACK     = 3'd4;
  localparam logic [2:0] BK_SDATA   = 3'd5;
  localparam logic [2:0] BK_UNUSED6 = 3'd6;
  localparam logic [2:0] BK_UNUSED7 = 3'd7;

  localparam logic [ADDR_W-1:0] ADDR_PROTOCOL_MODE = {REG_PROTOCOL_MODE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_OWN_PROC_ID   = {REG_OWN_PROC_ID, 2'b00};

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int STALL_LIMIT     = 500;

  class coherence_scoreboard;
    logic [2:0]  mode = PROTO_MI;
    logic [3:0]  own_id = '0;
    slcc_out_t   pending_outcomes[$];
    int unsigned mismatches = 0;
    logic [2:0]  msg_list[2];
    int          msg_n;

    function void set_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
      if (addr[2] == REG_PROTOCOL_MODE) mode = data[2:0];
      else own_id = data[3:0];
    endfunction

    function bit state_used(logic [2:0] p, logic [3:0] st);
      bit used;
      case (st)
        ST_I, ST_M, ST_IM: used = 1'b1;
        ST_S, ST_SM:       used = (p != PROTO_MI);
        ST_IS:             used = (p == PROTO_MSI);
        ST_E, ST_ISE:      used = (p == PROTO_MESI || p == PROTO_MOESI || p == PROTO_MESIF);
        ST_O:              used = (p == PROTO_MOESI);
        ST_F:              used = (p == PROTO_MESIF);
        default:           used = 1'b0;
      endcase
      return used;
    endfunction

    function void add_msg(logic [2:0] m);
      if (msg_n < 2) begin
        msg_list[1'(msg_n)] = m;
        msg_n++;
      end
    endfunction

    // Only requests draw an Ack
    function void ack_if(logic [2:0] k);
      if (k == BK_RD || k == BK_WR) add_msg(MS_ACK);
    endfunction

    function slcc_out_t next_line_outcome(slcc_in_t w);
      slcc_out_t  r;
      logic [2:0] p;
      logic [2:0] k;
      logic [3:0] st;
      logic       rd;
      r = '0;
      msg_n = 0;
      msg_list[0] = MS_NONE;
      msg_list[1] = MS_NONE;
      p = (mode > PROTO_MESIF) ? PROTO_MI : mode;
      k = w.bus_kind;
      st = w.line_state;
      rd = w.is_read_access;
      r.next_line_state = st;
      if (!state_used(p, st)) begin
        r.next_line_state = ST_I;
        r.bad_state = 1'b1;
      end else if (w.action == ACT_SNOOP) begin
        case (st)
          ST_I: ack_if(k);
          ST_M: begin
            if (p == PROTO_MI) begin
              add_msg(MS_DATA);
              r.cache_act = CA_INV;
              r.next_line_state = ST_I;
            end else if (p == PROTO_MSI) begin
              add_msg(MS_DATA);
              if (k == BK_RD) r.next_line_state = ST_S;
              else if (k == BK_WR) begin
                r.cache_act = CA_INV;
                r.next_line_state = ST_I;
              end
            end else if (k == BK_RD) begin
              add_msg(MS_SDATA);
              r.next_line_state = (p == PROTO_MOESI) ? ST_O : ST_S;
            end else if (k == BK_WR) begin
              add_msg(MS_DATA);
              r.cache_act = CA_INV;
              r.next_line_state = ST_I;
            end else ack_if(k);
          end
          ST_O, ST_F: begin
            if (k == BK_RD) begin
              add_msg(MS_SDATA);
              if (st == ST_F) r.next_line_state = ST_S;
            end else if (k == BK_WR) begin
              add_msg(MS_DATA);
              r.cache_act = CA_INV;
              r.next_line_state = ST_I;
            end else ack_if(k);
          end
          ST_E: begin
            if (k == BK_RD) begin
              add_msg(MS_SHARED);
              r.next_line_state = ST_S;
            end else if (k == BK_SHARED) r.next_line_state = ST_S;
            else if (k == BK_WR) begin
              add_msg(MS_ACK);
              r.cache_act = CA_INV;
              r.next_line_state = ST_I;
            end
          end
          ST_S: begin
            if (k == BK_WR) begin
              add_msg(MS_ACK);
              r.cache_act = CA_INV;
              r.next_line_state = ST_I;
            end else if (k == BK_RD) begin
              if (p == PROTO_MESI || p == PROTO_MOESI) add_msg(MS_SHARED);
              if (p != PROTO_MOESI) add_msg(MS_ACK);
            end
          end
          ST_SM, ST_IM: begin
            ack_if(k);
            if (k == BK_DATA || (p == PROTO_MI && k == BK_SHARED)) begin
              r.cache_act = CA_RECV;
              r.next_line_state = ST_M;
            end
          end
          ST_IS: begin
            ack_if(k);
            if (k == BK_DATA) begin
              r.cache_act = CA_RECV;
              r.next_line_state = ST_S;
            end
          end
          default: begin
            ack_if(k);
            if (k == BK_DATA) begin
              r.cache_act = CA_RECV;
              r.next_line_state = ST_E;
            end else if (k == BK_SHARED) begin
              r.cache_act = CA_RECV;
              r.next_line_state = (p == PROTO_MESIF) ? ST_F : ST_S;
            end
          end
        endcase
      end else begin
        case (st)
          ST_I: begin
            if (rd && p != PROTO_MI) begin
              add_msg(MS_BUSRD);
              r.next_line_state = (p == PROTO_MSI) ? ST_IS : ST_ISE;
            end else begin
              add_msg(MS_BUSWR);
              r.next_line_state = ST_IM;
            end
          end
          ST_M: r.perm_granted = 1'b1;
          ST_S, ST_O, ST_F: begin
            if (rd) r.perm_granted = 1'b1;
            else begin
              add_msg(MS_BUSWR);
              r.next_line_state = ST_SM;
            end
          end
          ST_E: begin
            r.perm_granted = 1'b1;
            if (!rd) r.next_line_state = ST_M;
          end
          ST_SM: r.perm_granted = rd;
          ST_IM: r.bad_state = 1'b1;
          default: begin
            if (!rd) begin
              add_msg(MS_BUSWR);
              r.next_line_state = ST_IM;
            end
          end
        endcase
      end
      if (msg_n > 0) begin
        r.first_msg = msg_list[0];
        r.msg_addr = w.line_addr;
        // Replies go back to the snooper; requests are broadcast
        if (w.action == ACT_SNOOP) begin
          r.msg_dest = w.source_proc;
          r.msg_number = w.message_number;
        end
      end
      if (msg_n > 1) r.second_msg = msg_list[1];
      return r;
    endfunction

    function void note_word(slcc_in_t w);
      pending_outcomes.push_back(next_line_outcome(w));
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(slcc_out_t got);
      slcc_out_t want;
      if (pending_outcomes.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_outcomes.pop_front();
      compare_field("next_line_state", 64'(want.next_line_state), 64'(got.next_line_state));
      compare_field("perm_granted", 64'(want.perm_granted), 64'(got.perm_granted));
      compare_field("cache_act", 64'(want.cache_act), 64'(got.cache_act));
      compare_field("bad_state", 64'(want.bad_state), 64'(got.bad_state));
      compare_field("first_msg", 64'(want.first_msg), 64'(got.first_msg));
      compare_field("second_msg", 64'(want.second_msg), 64'(got.second_msg));
      compare_field("msg_addr", want.msg_addr, got.msg_addr);
      compare_field("msg_dest", 64'(want.msg_dest), 64'(got.msg_dest));
      compare_field("msg_number", 64'(want.msg_number), 64'(got.msg_number));
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  slcc_in_t          in_data = '0;
  logic              out_strobe;
  slcc_out_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  coherence_scoreboard sb = new();
  int                  stall_cycles = 0;

  always #10 clk = ~clk;

  snooping_coherence_line_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        sb.set_reg(paddr, pwdata);
        moved = 1'b1;
      end
      if (start && !busy) begin
        sb.note_word(in_data);
        moved = 1'b1;
      end
      if (out_strobe) begin
        sb.check_word(out_data);
        moved = 1'b1;
      end
    end
    if (moved) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL snooping_coherence_line_controller");
    $finish;
  end

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // drop the select for one cycle before the next transfer
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Leave start high; the caller lowers it for a gap
  task automatic send_word(slcc_in_t w);
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
  endtask

  // Hold until every outstanding result has been checked
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  function automatic slcc_in_t make_word(logic act, logic rd, logic [2:0] kind, logic [3:0] st,
                                         logic [63:0] addr, logic [3:0] src, logic [15:0] num);
    slcc_in_t w;
    w.action = act;
    w.is_read_access = rd;
    w.bus_kind = kind;
    w.line_state = st;
    w.line_addr = addr;
    w.source_proc = src;
    w.message_number = num;
    return w;
  endfunction

  initial begin
    logic [2:0]  phase_mode[NUM_PHASES];
    slcc_in_t    directed[$];
    slcc_in_t    w;
    logic [3:0]  line_now;
    logic [63:0] ones;
    int          pick;
    ones = '1;
    phase_mode = '{PROTO_MESIF, PROTO_MI, PROTO_MSI, PROTO_MESI, PROTO_MOESI,
                   PROTO_RSVD_A, PROTO_RSVD_C, PROTO_RSVD_B, PROTO_MESIF, PROTO_MOESI};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(ADDR_PROTOCOL_MODE, 32'(PROTO_MESIF));
    write_reg(ADDR_OWN_PROC_ID, 32'd15);
    directed.push_back(make_word(ACT_ACCESS, 1'b1, BK_RD, ST_I, ones, 4'hf, 16'hffff));
    directed.push_back(make_word(ACT_ACCESS, 1'b0, BK_UNUSED7, ST_I, '0, 4'h0, 16'h0));
    directed.push_back(make_word(ACT_SNOOP, 1'b1, BK_RD, ST_M, ones, 4'hf, 16'hffff));
    directed.push_back(make_word(ACT_SNOOP, 1'b0, BK_RD, ST_M, '0, 4'h0, 16'h0));
    directed.push_back(make_word(ACT_SNOOP, 1'b0, BK_WR, ST_F, 64'h5a5a, 4'h9, 16'h1234));
    directed.push_back(make_word(ACT_SNOOP, 1'b0, BK_SHARED, ST_ISE, 64'h80, 4'h3, 16'h77));
    directed.push_back(make_word(ACT_SNOOP, 1'b1, BK_DATA, ST_ISE, 64'h40, 4'h2, 16'h88));
    directed.push_back(make_word(ACT_SNOOP, 1'b0, BK_SDATA, ST_SM, 64'h44, 4'h5, 16'h9));
    directed.push_back(make_word(ACT_SNOOP, 1'b0, BK_ACK, ST_M, 64'h48, 4'h6, 16'ha));
    // access while in IM
    directed.push_back(make_word(ACT_ACCESS, 1'b1, BK_RD, ST_IM, ones, 4'h1, 16'h1));
    // unknown bus kinds act like Ack
    directed.push_back(make_word(ACT_SNOOP, 1'b0, BK_UNUSED6, ST_I, 64'h100, 4'h7, 16'h2));
    directed.push_back(make_word(ACT_SNOOP, 1'b0, BK_UNUSED7, ST_M, 64'h104, 4'h8, 16'h3));
    // state codes past ISE and states this protocol does not use
    for (int s = 10; s < 16; s++)
      directed.push_back(make_word(s[0], s[1], BK_RD, 4'(s), ones, 4'hf, 16'hffff));
    directed.push_back(make_word(ACT_ACCESS, 1'b0, BK_RD, ST_IS, 64'h200, 4'h4, 16'h4));
    directed.push_back(make_word(ACT_SNOOP, 1'b0, BK_RD, ST_O, 64'h204, 4'h4, 16'h5));
    directed.push_back(make_word(ACT_SNOOP, 1'b0, BK_RD, ST_S, 64'h208, 4'ha, 16'h6));
    directed.push_back(make_word(ACT_ACCESS, 1'b0, BK_WR, ST_E, 64'h20c, 4'hb, 16'h7));
    directed.push_back(make_word(ACT_ACCESS, 1'b0, BK_WR, ST_S, 64'h210, 4'hc, 16'h8));
    foreach (directed[i]) send_word(directed[i]);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(ADDR_PROTOCOL_MODE, 32'(phase_mode[ph]));
      write_reg(ADDR_OWN_PROC_ID, (ph == 0) ? 32'd0 : (ph == 1) ? 32'd15 : $urandom_range(0, 15));
      line_now = ST_I;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        w.action = 1'($urandom_range(0, 1));
        w.is_read_access = 1'($urandom_range(0, 1));
        w.bus_kind = 3'(($urandom_range(0, 15) == 0) ? $urandom_range(6, 7)
                                                     : $urandom_range(0, 5));
        // mostly follow the line through its own transitions
        pick = $urandom_range(0, 99);
        if (pick < 60) w.line_state = line_now;
        else if (pick < 85) w.line_state = 4'($urandom_range(0, 9));
        else w.line_state = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 15);
        if (pick == 0) w.line_addr = '0;
        else if (pick == 1) w.line_addr = ones;
        else w.line_addr = {$urandom, $urandom};
        w.source_proc = 4'($urandom_range(0, 15));
        w.message_number = 16'($urandom_range(0, 65535));
        line_now = sb.next_line_outcome(w).next_line_state;
        send_word(w);
        if (ph < NUM_PHASES - 1 && $urandom_range(0, 4) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
      end
      drain();
    end

    // let any stray result surface
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) $display("PASS snooping_coherence_line_controller");
    else $display("FAIL snooping_coherence_line_controller");
    $finish;
  end

endmodule
